### hdl/srbp_pkg.sv
`default_nettype none
package srbp_pkg;

  // Low part width limit and the code tail (one separator zero plus the low bits).
  localparam int LOW_W  = 32;
  localparam int TAIL_W = LOW_W + 1;

  // Outcome of one merge step of the shared bit-merge unit.
  typedef struct packed {
    logic       done;     // open byte filled
    logic       last;     // no further byte for this request
    logic [7:0] data;     // completed byte value
    logic [7:0] partial;  // open byte after the step
    logic [2:0] pos;      // next free bit after the step
  } srbp_emit_t;

endpackage
`default_nettype wire

### hdl/srbp_map.sv
`default_nettype none
module srbp_map import srbp_pkg::*; #(
  parameter int MAX_ONES = 255,
  parameter int ONES_W   = 8,
  parameter int REM_W    = 9
) (
  input  wire logic signed [31:0]     coefficient,
  input  wire logic        [4:0]      log2_sigma,
  output logic                        too_long,
  output logic             [ONES_W-1:0] ones,
  output logic             [REM_W-1:0]  rem,
  output logic             [TAIL_W-1:0] tail
);

  logic        [5:0]  k;
  logic        [32:0] low_mask;
  logic        [31:0] low;
  logic signed [33:0] biased;
  logic signed [33:0] z1;
  logic signed [34:0] dbl;
  logic signed [34:0] ones_full;

  always_comb begin
    k        = {1'b0, log2_sigma} + 6'd1;
    low_mask = ~({33{1'b1}} << k);
    low      = coefficient & low_mask[31:0];
    // Round-half-up split: z = z1 * 2^k + z0 with z0 centred.
    biased   = {{2{coefficient[31]}}, coefficient} + (34'sd1 <<< (k - 6'd1));
    z1       = biased >>> k;
    dbl      = {z1[33], z1} <<< 1;
    ones_full = (z1 <= 34'sd0) ? -dbl : dbl - 35'sd1;
    too_long = ones_full > 35'sd0 + 35'(MAX_ONES);
    ones     = ONES_W'(ones_full);
    rem      = REM_W'(ones) + REM_W'(k) + REM_W'(1);
    tail     = {low, 1'b0};
  end

endmodule
`default_nettype wire

### hdl/srbp_merge.sv
`default_nettype none
module srbp_merge import srbp_pkg::*; #(
  parameter int ONES_W = 8,
  parameter int REM_W  = 9
) (
  input  wire logic [7:0]        partial,
  input  wire logic [2:0]        pos,
  input  wire logic [ONES_W-1:0] ones,
  input  wire logic [TAIL_W-1:0] tail,
  input  wire logic [REM_W-1:0]  rem,
  output srbp_emit_t             emit,
  output logic [ONES_W-1:0]      ones_nxt,
  output logic [TAIL_W-1:0]      tail_nxt,
  output logic [REM_W-1:0]       rem_nxt
);

  logic [8:0] ones9;
  logic [3:0] space;
  logic       rem_ge;
  logic [3:0] c;
  logic [7:0] chunk;
  logic [7:0] mask;
  logic [7:0] bits;
  logic [7:0] merged;
  logic [3:0] take;

  always_comb begin
    ones9  = 9'(ones);
    space  = 4'd8 - {1'b0, pos};
    rem_ge = rem >= REM_W'(space);
    c      = rem_ge ? space : rem[3:0];
    // Next eight code bits: the pending ones, then the tail.
    for (int i = 0; i < 8; i++) begin
      if (ones9 > 9'(i)) chunk[i] = 1'b1;
      else               chunk[i] = tail[3'(i) - ones9[2:0]];
    end
    mask   = 8'hFF >> (4'd8 - c);
    bits   = (chunk & mask) << pos;
    merged = partial | bits;

    emit.done    = rem_ge;
    emit.data    = merged;
    emit.last    = rem_ge && ((rem - REM_W'(c)) < REM_W'(8));
    emit.partial = rem_ge ? 8'h00 : merged;
    emit.pos     = rem_ge ? 3'd0 : pos + c[2:0];

    take = 4'd0;
    if (ones9 >= {5'b0, c}) begin
      ones_nxt = ones - ONES_W'(c);
      tail_nxt = tail;
    end else begin
      take     = c - ones9[3:0];
      ones_nxt = '0;
      tail_nxt = tail >> take;
    end
    rem_nxt = rem - REM_W'(c);
  end

endmodule
`default_nettype wire

### hdl/signed_rice_bit_packer.sv
// Signed Rice bit packer. Each encode request (in_tuser = 0) splits the signed
// coefficient into a centred low part of log2_sigma+1 bits and a high part,
// writes the high part as a unary run of ones and a zero, then the low bits LSB
// first, and emits every completed byte on the out channel, LSB written first;
// tlast marks the last byte caused by a request, and an encode that fills no
// byte emits nothing. A finish request (in_tuser = 1) writes a one, zero-pads
// the open byte and emits it. A coefficient whose unary run would exceed
// MAX_ONES writes nothing and emits one byte 0x00 with tuser (too_long) and
// tlast set. A request is accepted and its coefficient mapped; then, unless
// the coefficient is dropped, the shared bit-merge unit runs its steps, each
// filling the open byte by up to eight bits. An encode writes ones +
// log2_sigma + 2 code bits, and the input is not ready until the request is
// done. A stalled output holds the merge unit. Write log2_sigma only while the
// block is idle.
`default_nettype none
module signed_rice_bit_packer import srbp_pkg::*; #(
  parameter int MAX_ONES = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: log2_sigma
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,
  // request in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] coefficient
  input  wire logic [0:0]  in_tuser,   // [0] req_type
  // packed bytes out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // last_of_run
  output logic [0:0]       out_tuser   // [0] too_long
);

  localparam int ONES_W = (MAX_ONES < 2) ? 1 : $clog2(MAX_ONES + 1);
  localparam int REM_W  = $clog2(MAX_ONES + 34);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAP  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              type_r;
  logic [31:0]       coef_r;
  logic [4:0]        log2_r;
  logic [7:0]        partial_r, partial_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [ONES_W-1:0] ones_r, ones_nxt;
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_user_r, out_user_nxt;

  logic              map_too_long;
  logic [ONES_W-1:0] map_ones;
  logic [REM_W-1:0]  map_rem;
  logic [TAIL_W-1:0] map_tail;

  srbp_emit_t        step;
  logic [ONES_W-1:0] step_ones;
  logic [TAIL_W-1:0] step_tail;
  logic [REM_W-1:0]  step_rem;

  logic              slot_free;

  srbp_map #(.MAX_ONES(MAX_ONES), .ONES_W(ONES_W), .REM_W(REM_W)) u_map (
    .coefficient (coef_r),
    .log2_sigma  (log2_r),
    .too_long    (map_too_long),
    .ones        (map_ones),
    .rem         (map_rem),
    .tail        (map_tail)
  );

  srbp_merge #(.ONES_W(ONES_W), .REM_W(REM_W)) u_merge (
    .partial  (partial_r),
    .pos      (pos_r),
    .ones     (ones_r),
    .tail     (tail_r),
    .rem      (rem_r),
    .emit     (step),
    .ones_nxt (step_ones),
    .tail_nxt (step_tail),
    .rem_nxt  (step_rem)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // The output register frees up in the same cycle it is taken.
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    partial_nxt   = partial_r;
    pos_nxt       = pos_r;
    ones_nxt      = ones_r;
    tail_nxt      = tail_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MAP;
      end
      ST_MAP: begin
        if (type_r) begin
          // Finish: one pending one, then zeros up to the byte boundary.
          ones_nxt  = ONES_W'(1);
          tail_nxt  = '0;
          rem_nxt   = REM_W'(4'd8 - {1'b0, pos_r});
          state_nxt = ST_RUN;
        end else if (map_too_long) begin
          // Drop the coefficient; hold the stream state.
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = 8'h00;
            out_last_nxt  = 1'b1;
            out_user_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          ones_nxt  = map_ones;
          tail_nxt  = map_tail;
          rem_nxt   = map_rem;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // Advance one merge step unless a completed byte has nowhere to go.
        if (slot_free) begin
          partial_nxt = step.partial;
          pos_nxt     = step.pos;
          ones_nxt    = step_ones;
          tail_nxt    = step_tail;
          rem_nxt     = step_rem;
          if (step.done) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = step.data;
            out_last_nxt  = step.last;
            out_user_nxt  = 1'b0;
          end
          if (step_rem == '0) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      log2_r      <= 5'd0;
      partial_r   <= 8'h00;
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      partial_r   <= partial_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) log2_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      type_r <= in_tuser[0];
      coef_r <= in_tdata;
    end
    ones_r     <= ones_nxt;
    tail_r     <= tail_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule
`default_nettype wire

### hdl/srbp_checker.sv
`default_nettype none
module srbp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [0:0] out_tuser
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // A dropped coefficient reports a zero byte that closes its request.
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata == 8'h00))
    else $error("too_long result malformed");

  // One request at a time: drop ready right after an accepted request.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind signed_rice_bit_packer srbp_checker u_srbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

### verif/signed_rice_bit_packer_test.sv
`timescale 1ns / 1ps

module signed_rice_bit_packer_test;

  localparam int MAX_ONES      = 255;
  // An encode that fills no byte may still be in flight when the last
  // expected byte arrives; hold this many cycles before touching log2_sigma.
  localparam int SETTLE_CYCLES = 48;
  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT    = 4000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 17;

  typedef enum logic {REQ_ENCODE = 1'b0, REQ_FINISH = 1'b1} req_kind_e;
  typedef enum logic {ROW_SIGMA, ROW_REQUEST} row_kind_e;

  // One emitted byte as the out channel carries it.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       too_long;
  } packed_byte_t;

  // One line of the directed table: a log2_sigma write or a request. Rows
  // with a hand-written result carry it in 'result'; all others use the
  // bit-packing predictor.
  typedef struct {
    row_kind_e    kind;
    req_kind_e    req;
    logic [31:0]  value;
    logic         typed;
    packed_byte_t result;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] coefficient
  logic [0:0]  in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tlast;  // last_of_run
  logic [0:0]  out_tuser;  // [0] too_long

  // Predictor state: open byte, next free bit, and the low part width code.
  logic [7:0]   open_byte;
  logic [2:0]   open_pos;
  logic [4:0]   sigma;

  packed_byte_t pending_bytes[$];
  stim_row_t    stim_rows[$];
  packed_byte_t seen_head;
  int           mismatches;
  int           quiet_cycles;
  bit           steady_phase;

  signed_rice_bit_packer #(.MAX_ONES(MAX_ONES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Write one bit into the open byte; queue the byte once it is full.
  task automatic write_bit(input logic b, inout int emitted);
    packed_byte_t entry;
    begin
      open_byte[open_pos] = b;
      if (open_pos == 3'd7) begin
        entry.data     = open_byte;
        entry.last     = 1'b0;
        entry.too_long = 1'b0;
        pending_bytes.push_back(entry);
        emitted++;
        open_byte = 8'd0;
        open_pos  = 3'd0;
      end else begin
        open_pos = open_pos + 3'd1;
      end
    end
  endtask

  // Work out the bytes one accepted request produces and queue them.
  task automatic pack_request(input req_kind_e req, input logic [31:0] coef);
    packed_byte_t entry;
    logic [63:0]  span;
    logic [63:0]  low;
    longint       z;
    longint       z0;
    longint       z1;
    longint       ones;
    int           k;
    int           j;
    int           emitted;
    begin
      emitted = 0;
      if (req == REQ_FINISH) begin
        // Close the stream with a one and flush the open byte, padded.
        open_byte[open_pos] = 1'b1;
        entry.data     = open_byte;
        entry.last     = 1'b1;
        entry.too_long = 1'b0;
        pending_bytes.push_back(entry);
        open_byte = 8'd0;
        open_pos  = 3'd0;
      end else begin
        k    = int'(sigma) + 1;
        span = 64'd1 << k;
        low  = {32'd0, coef} & (span - 64'd1);
        z    = longint'($signed(coef));
        // Re-center the low part into [-span/2, span/2).
        z0   = longint'(low);
        if (low >= (span >> 1))
          z0 = z0 - longint'(span);
        z1   = (z - z0) / longint'(span);
        ones = (z1 <= 0) ? -2 * z1 : 2 * z1 - 1;
        if (ones > MAX_ONES) begin
          // Drop the coefficient: state stays, one flagged zero byte.
          entry.data     = 8'd0;
          entry.last     = 1'b1;
          entry.too_long = 1'b1;
          pending_bytes.push_back(entry);
        end else begin
          for (j = 0; j < ones; j++)
            write_bit(1'b1, emitted);
          write_bit(1'b0, emitted);
          for (j = 0; j < k; j++)
            write_bit(low[j], emitted);
          // Mark the final byte of this request.
          if (emitted > 0) begin
            entry = pending_bytes[pending_bytes.size() - 1];
            entry.last = 1'b1;
            pending_bytes[pending_bytes.size() - 1] = entry;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers: all inputs change at the falling edge.
  // ---------------------------------------------------------------------

  // Present one request, with a random idle burst in front of it unless the
  // run is in its steady part; return right after the accepting edge with
  // tvalid still high so back-to-back requests need no toggle.
  task automatic send_request(input req_kind_e req, input logic [31:0] coef,
                              input logic typed, input packed_byte_t result);
    begin
      @(negedge clk);
      if (!steady_phase && $urandom_range(0, 3) == 0) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata  = coef;
      in_tuser  = req;
      do @(posedge clk); while (!in_tready);
      pack_request(req, coef);
      // A typed row replaces the single predicted byte by its own.
      if (typed)
        pending_bytes[pending_bytes.size() - 1] = result;
    end
  endtask

  // Drop the request line, wait until the block is drained and settled,
  // then write log2_sigma.
  task automatic write_sigma(input logic [4:0] value);
    begin
      @(negedge clk);
      in_tvalid = 1'b0;
      while (pending_bytes.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_data  = value;
      do @(posedge clk); while (!cfg_ready);
      sigma = value;
      @(negedge clk);
      cfg_valid = 1'b0;
    end
  endtask

  task automatic add_row(input row_kind_e kind, input req_kind_e req,
                         input logic [31:0] value, input logic typed,
                         input logic [7:0] data, input logic last,
                         input logic too_long);
    stim_row_t row;
    begin
      row.kind            = kind;
      row.req             = req;
      row.value           = value;
      row.typed           = typed;
      row.result.data     = data;
      row.result.last     = last;
      row.result.too_long = too_long;
      stim_rows.push_back(row);
    end
  endtask

  // Mostly coefficients whose unary run fits, scaled to the current low
  // part width; now and then a full-range word or a corner value.
  function automatic logic [31:0] make_coefficient(input int k);
    logic [31:0] mag;
    int          top;
    int          width;
    int          sel;
    begin
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        make_coefficient = $urandom;
      end else if (sel == 2) begin
        case ($urandom_range(0, 3))
          0:       make_coefficient = 32'h7fff_ffff;
          1:       make_coefficient = 32'h8000_0000;
          2:       make_coefficient = 32'h0000_0000;
          default: make_coefficient = 32'hffff_ffff;
        endcase
      end else begin
        top   = (k + 7 > 31) ? 31 : k + 7;
        width = $urandom_range(0, top);
        mag   = (width == 0) ? 32'd0 : ($urandom & (32'hffff_ffff >> (32 - width)));
        make_coefficient = $urandom_range(0, 1) ? -mag : mag;
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random back-pressure bursts, none in the steady part.
  // ---------------------------------------------------------------------
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!steady_phase && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    begin
      $display("mismatch at %0t: %s expected %h got %h", $realtime, field, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted byte with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch("unexpected byte", 8'h00, out_tdata);
      end else begin
        seen_head = pending_bytes.pop_front();
        if (out_tdata !== seen_head.data)
          note_mismatch("out_byte", seen_head.data, out_tdata);
        if (out_tlast !== seen_head.last)
          note_mismatch("last_of_run", {7'd0, seen_head.last}, {7'd0, out_tlast});
        if (out_tuser[0] !== seen_head.too_long)
          note_mismatch("too_long", {7'd0, seen_head.too_long}, {7'd0, out_tuser[0]});
      end
    end
  end

  // Hang detection: count cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("signed_rice_bit_packer_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t    row;
    packed_byte_t no_result;
    int           r;
    int           p;
    int           i;
    logic [4:0]   phase_sigma;

    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 5'd0;
    in_tvalid    = 1'b0;
    in_tdata     = 32'd0;
    in_tuser     = REQ_ENCODE;
    open_byte    = 8'd0;
    open_pos     = 3'd0;
    sigma        = 5'd0;
    mismatches   = 0;
    steady_phase = 1'b0;
    no_result    = '{8'd0, 1'b0, 1'b0};

    // Directed table; log2_sigma starts at its reset value 0 (k = 1).
    // Finish on an empty byte right after reset gives a lone 0x01.
    add_row(ROW_REQUEST, REQ_FINISH, 32'h0000_0000, 1'b1, 8'h01, 1'b1, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h0000_0000, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h0000_0001, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'hffff_ffff, 1'b0, 8'h00, 1'b0, 1'b0);
    // Extremes with k = 1 overflow the unary run: flagged zero byte.
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h7fff_ffff, 1'b1, 8'h00, 1'b1, 1'b1);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h8000_0000, 1'b1, 8'h00, 1'b1, 1'b1);
    add_row(ROW_REQUEST, REQ_FINISH, 32'hffff_ffff, 1'b0, 8'h00, 1'b0, 1'b0);
    // Widest low part: the code is a zero plus all 32 coefficient bits.
    add_row(ROW_SIGMA,   REQ_ENCODE, 32'd31,        1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h7fff_ffff, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h8000_0000, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'hffff_ffff, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_FINISH, 32'h0000_0000, 1'b0, 8'h00, 1'b0, 1'b0);
    // Next to the widest low part, k = 31: short unary runs at the extremes.
    add_row(ROW_SIGMA,   REQ_ENCODE, 32'd30,        1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h7fff_ffff, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'h8000_0000, 1'b0, 8'h00, 1'b0, 1'b0);
    // Back to k = 1 to hit the unary limit exactly and just above it.
    add_row(ROW_SIGMA,   REQ_ENCODE, 32'd0,         1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, 32'd256,       1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_ENCODE, -32'sd256,     1'b1, 8'h00, 1'b1, 1'b1);
    add_row(ROW_REQUEST, REQ_ENCODE, -32'sd255,     1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_FINISH, 32'h0000_0000, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(ROW_REQUEST, REQ_FINISH, 32'h0000_0000, 1'b1, 8'h01, 1'b1, 1'b0);

    // Hold reset, then release it between edges.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < stim_rows.size(); r++) begin
      row = stim_rows[r];
      if (row.kind == ROW_SIGMA)
        write_sigma(row.value[4:0]);
      else
        send_request(row.req, row.value, row.typed, row.result);
    end

    // Random phases, each under its own log2_sigma; the last one runs
    // without idling on either side.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_sigma = 5'd5;
        1:       phase_sigma = 5'd30;
        2:       phase_sigma = 5'd31;
        3:       phase_sigma = 5'd0;
        4:       phase_sigma = 5'd17;
        default: phase_sigma = 5'($urandom_range(0, 31));
      endcase
      write_sigma(phase_sigma);
      steady_phase = (p == PHASES - 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_request(REQ_FINISH, $urandom, 1'b0, no_result);
        else
          send_request(REQ_ENCODE, make_coefficient(int'(sigma) + 1), 1'b0, no_result);
      end
    end

    // Drain: drop the request, wait for every expected byte, then settle.
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("signed_rice_bit_packer_test OK");
    end else begin
      $display("signed_rice_bit_packer_test NOT OK");
    end
    $finish;
  end

endmodule
